// File: rtl/core/a2d_pkg.sv
// Package for the 2D affine transform unit: widths, codes, micro-op table,
// CORDIC arctangent table and saturation helpers.
// Depends on nothing; the multiplier, divider, CORDIC, top level and testbench use it.
package a2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PROD_W = 64 - FRAC_BITS;
	localparam int ACC_W = 66 - FRAC_BITS;
	localparam int DIV_W = (34 + FRAC_BITS > ACC_W) ? 34 + FRAC_BITS : ACC_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int V_W = 62 - FRAC_BITS;
	localparam int RED_STEPS = 30 - FRAC_BITS;
	localparam int RED_W = $clog2(RED_STEPS + 2);
	localparam int CW = 35;
	localparam int CORDIC_STEPS = 30;
	localparam int ANG_SHIFT = 30 - FRAC_BITS;

	localparam logic [33:0] ANG_TWO_PI_U = 34'd6746518852;
	localparam logic signed [CW-1:0] ANG_PI = CW'(64'sd3373259426);
	localparam logic signed [CW-1:0] ANG_TWO_PI = CW'(64'sd6746518852);
	localparam logic signed [CW-1:0] ANG_HALF_PI = CW'(64'sd1686629713);
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [2:0] {
		FN_IDENT = 3'd0,
		FN_TRANSLATE = 3'd1,
		FN_SCALE = 3'd2,
		FN_ROTATE = 3'd3,
		FN_APPLY = 3'd4,
		FN_INVERT = 3'd5,
		FN_DET = 3'd6
	} func_t;

	typedef enum logic [3:0] {
		SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5, SRC_N0, SRC_N1, SRC_N3, SRC_N4,
		SRC_A, SRC_B, SRC_SIN, SRC_NSIN, SRC_COS
	} src_t;

	typedef enum logic [1:0] {MD_LOAD, MD_ADD, MD_SUB} mode_t;
	typedef enum logic [1:0] {ADD_NONE, ADD_M2, ADD_M5} addend_t;
	typedef enum logic [2:0] {FIN_NONE, FIN_WR, FIN_WRNEG, FIN_OUTX, FIN_OUTY, FIN_DET} fin_t;
	typedef enum logic {UK_MUL, UK_DIV} kind_t;

	typedef struct packed {
		kind_t kind;
		src_t src_a;
		src_t src_b;
		mode_t mode;
		addend_t addend;
		fin_t fin;
		logic [2:0] dst;
		logic last;
	} uop_t;

	typedef enum logic [2:0] {
		CS_IDLE, CS_CORDIC, CS_ISSUE, CS_ACC, CS_DIV, CS_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		CR_IDLE, CR_RED, CR_FOLD1, CR_FOLD2, CR_ITER, CR_FIN
	} cor_state_t;

	function automatic uop_t mk(input kind_t k, input src_t a, input src_t b,
			input mode_t md, input addend_t ad, input fin_t f, input logic [2:0] d,
			input logic l);
		uop_t u;
		u.kind = k;
		u.src_a = a;
		u.src_b = b;
		u.mode = md;
		u.addend = ad;
		u.fin = f;
		u.dst = d;
		u.last = l;
		return u;
	endfunction

	// Sequence of multiply and divide steps for each operation.
	function automatic uop_t uop_lookup(input logic [2:0] fn, input logic [3:0] idx);
		uop_t u;
		u = mk(UK_MUL, SRC_M0, SRC_A, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b1);
		case (fn)
			FN_TRANSLATE, FN_APPLY: begin
				case (idx)
					4'd0: u = mk(UK_MUL, SRC_M0, SRC_A, MD_LOAD, ADD_M2, FIN_NONE, 3'd0, 1'b0);
					4'd1: u = mk(UK_MUL, SRC_M1, SRC_B, MD_ADD, ADD_NONE,
						(fn == FN_APPLY) ? FIN_OUTX : FIN_WR, 3'd2, 1'b0);
					4'd2: u = mk(UK_MUL, SRC_M3, SRC_A, MD_LOAD, ADD_M5, FIN_NONE, 3'd0, 1'b0);
					default: u = mk(UK_MUL, SRC_M4, SRC_B, MD_ADD, ADD_NONE,
						(fn == FN_APPLY) ? FIN_OUTY : FIN_WR, 3'd5, 1'b1);
				endcase
			end
			FN_SCALE: begin
				case (idx)
					4'd0: u = mk(UK_MUL, SRC_M0, SRC_A, MD_LOAD, ADD_NONE, FIN_WR, 3'd0, 1'b0);
					4'd1: u = mk(UK_MUL, SRC_M3, SRC_A, MD_LOAD, ADD_NONE, FIN_WR, 3'd3, 1'b0);
					4'd2: u = mk(UK_MUL, SRC_M1, SRC_B, MD_LOAD, ADD_NONE, FIN_WR, 3'd1, 1'b0);
					default: u = mk(UK_MUL, SRC_M4, SRC_B, MD_LOAD, ADD_NONE, FIN_WR, 3'd4, 1'b1);
				endcase
			end
			FN_ROTATE: begin
				case (idx)
					4'd0: u = mk(UK_MUL, SRC_M0, SRC_COS, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					4'd1: u = mk(UK_MUL, SRC_M1, SRC_SIN, MD_ADD, ADD_NONE, FIN_WR, 3'd0, 1'b0);
					4'd2: u = mk(UK_MUL, SRC_M0, SRC_NSIN, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					4'd3: u = mk(UK_MUL, SRC_M1, SRC_COS, MD_ADD, ADD_NONE, FIN_WR, 3'd1, 1'b0);
					4'd4: u = mk(UK_MUL, SRC_M3, SRC_COS, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					4'd5: u = mk(UK_MUL, SRC_M4, SRC_SIN, MD_ADD, ADD_NONE, FIN_WR, 3'd3, 1'b0);
					4'd6: u = mk(UK_MUL, SRC_M3, SRC_NSIN, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					default: u = mk(UK_MUL, SRC_M4, SRC_COS, MD_ADD, ADD_NONE, FIN_WR, 3'd4, 1'b1);
				endcase
			end
			FN_DET: begin
				case (idx)
					4'd0: u = mk(UK_MUL, SRC_M0, SRC_M4, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					default: u = mk(UK_MUL, SRC_M1, SRC_M3, MD_SUB, ADD_NONE, FIN_OUTX, 3'd0, 1'b1);
				endcase
			end
			FN_INVERT: begin
				case (idx)
					4'd0: u = mk(UK_MUL, SRC_M0, SRC_M4, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					4'd1: u = mk(UK_MUL, SRC_M1, SRC_M3, MD_SUB, ADD_NONE, FIN_DET, 3'd0, 1'b0);
					4'd2: u = mk(UK_DIV, SRC_M4, SRC_M4, MD_ADD, ADD_NONE, FIN_WR, 3'd0, 1'b0);
					4'd3: u = mk(UK_DIV, SRC_M1, SRC_M1, MD_SUB, ADD_NONE, FIN_WR, 3'd1, 1'b0);
					4'd4: u = mk(UK_DIV, SRC_M3, SRC_M3, MD_SUB, ADD_NONE, FIN_WR, 3'd3, 1'b0);
					4'd5: u = mk(UK_DIV, SRC_M0, SRC_M0, MD_ADD, ADD_NONE, FIN_WR, 3'd4, 1'b0);
					4'd6: u = mk(UK_MUL, SRC_N0, SRC_M2, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					4'd7: u = mk(UK_MUL, SRC_N1, SRC_M5, MD_ADD, ADD_NONE, FIN_WRNEG, 3'd2, 1'b0);
					4'd8: u = mk(UK_MUL, SRC_N3, SRC_M2, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b0);
					default: u = mk(UK_MUL, SRC_N4, SRC_M5, MD_ADD, ADD_NONE, FIN_WRNEG, 3'd5,
						1'b1);
				endcase
			end
			default: u = mk(UK_MUL, SRC_M0, SRC_A, MD_LOAD, ADD_NONE, FIN_NONE, 3'd0, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic [31:0] atan_lookup(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > ACC_W'(64'sd2147483647)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < ACC_W'(-64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_div(input logic signed [DIV_W-1:0] v);
		logic signed [31:0] r;
		if (v > DIV_W'(64'sd2147483647)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < DIV_W'(-64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/a2d_in_if.sv
// Input channel of the 2D affine transform unit: valid, ready and one operation.
// Depends on nothing.
interface a2d_in_if;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, output func, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input func, input operand_a, input operand_b,
		output ready);
endinterface

// File: rtl/core/a2d_out_if.sv
// Output channel of the 2D affine transform unit: valid, ready and one result.
// Depends on nothing.
interface a2d_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic singular;

	modport source (output valid, output result_x, output result_y, output singular,
		input ready);
	modport sink (input valid, input result_x, input result_y, input singular,
		output ready);
endinterface

// File: rtl/core/a2d_mul.sv
// Shared registered fixed-point multiplier: full product shifted down by the
// fraction width, rounding toward minus infinity. Depends on a2d_pkg.
module a2d_mul (
	input logic clk,
	input logic signed [31:0] a,
	input logic signed [31:0] b,
	output logic signed [a2d_pkg::PROD_W-1:0] prod_q
);
	logic signed [63:0] full;

	assign full = a * b;

	always_ff @(posedge clk) begin
		prod_q <= a2d_pkg::PROD_W'(full >>> a2d_pkg::FRAC_BITS);
	end
endmodule

// File: rtl/core/a2d_div.sv
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on a2d_pkg.
module a2d_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [a2d_pkg::DIV_W-1:0] dividend,
	input logic signed [a2d_pkg::DIV_W-1:0] divisor,
	output logic done,
	output logic signed [a2d_pkg::DIV_W-1:0] quot
);
	localparam int W = a2d_pkg::DIV_W;

	logic [a2d_pkg::DIV_CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic neg_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic [W:0] rem_q;
	logic [W:0] rem_sh;
	logic [W:0] rem_sub;
	logic fits;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits = rem_sh >= {1'b0, den_q};
	assign done = done_q;
	assign quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= a2d_pkg::DIV_CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == a2d_pkg::DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			den_q <= divisor[W-1] ? W'(-divisor) : W'(divisor);
			neg_q <= dividend[W-1] ^ divisor[W-1];
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end
endmodule

// File: rtl/core/a2d_cordic.sv
// Sine and cosine of a radian angle: range reduction by repeated subtraction,
// folding to a half turn and a 30-step rotation CORDIC. Depends on a2d_pkg.
module a2d_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] angle,
	output logic done,
	output logic signed [31:0] sin_q,
	output logic signed [31:0] cos_q
);
	localparam int VW = a2d_pkg::V_W;
	localparam int CW = a2d_pkg::CW;

	a2d_pkg::cor_state_t st_q;
	a2d_pkg::cor_state_t st_d;
	logic [VW-1:0] mag_q;
	logic sgn_q;
	logic [a2d_pkg::RED_W-1:0] red_q;
	logic signed [CW-1:0] r_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic [4:0] i_q;
	logic fneg_q;
	logic done_q;
	logic signed [VW-1:0] v_ext;
	logic [VW:0] red_cmp;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		return a2d_pkg::atan_lookup(i);
	endfunction

	assign v_ext = VW'(angle) <<< a2d_pkg::ANG_SHIFT;
	assign red_cmp = (VW + 1)'(a2d_pkg::ANG_TWO_PI_U) << (red_q - 1'b1);
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = CW'(atan_val(i_q));
	assign xs = fneg_q ? -x_q : x_q;
	assign ys = fneg_q ? -y_q : y_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= a2d_pkg::CR_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			a2d_pkg::CR_IDLE: if (start) st_d = a2d_pkg::CR_RED;
			a2d_pkg::CR_RED: if (red_q == '0) st_d = a2d_pkg::CR_FOLD1;
			a2d_pkg::CR_FOLD1: st_d = a2d_pkg::CR_FOLD2;
			a2d_pkg::CR_FOLD2: st_d = a2d_pkg::CR_ITER;
			a2d_pkg::CR_ITER: begin
				if (i_q == 5'(a2d_pkg::CORDIC_STEPS - 1)) st_d = a2d_pkg::CR_FIN;
			end
			a2d_pkg::CR_FIN: st_d = a2d_pkg::CR_IDLE;
			default: st_d = a2d_pkg::CR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == a2d_pkg::CR_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			a2d_pkg::CR_IDLE: begin
				mag_q <= v_ext[VW-1] ? VW'(-v_ext) : VW'(v_ext);
				sgn_q <= v_ext[VW-1];
				red_q <= a2d_pkg::RED_W'(a2d_pkg::RED_STEPS);
			end
			a2d_pkg::CR_RED: begin
				if (red_q != '0) begin
					if ({1'b0, mag_q} >= red_cmp) mag_q <= mag_q - VW'(red_cmp);
					red_q <= red_q - 1'b1;
				end else begin
					r_q <= sgn_q ? -$signed(CW'(mag_q)) : $signed(CW'(mag_q));
				end
			end
			a2d_pkg::CR_FOLD1: begin
				if (r_q > a2d_pkg::ANG_PI) r_q <= r_q - a2d_pkg::ANG_TWO_PI;
				else if (r_q < -a2d_pkg::ANG_PI) r_q <= r_q + a2d_pkg::ANG_TWO_PI;
				fneg_q <= 1'b0;
				x_q <= a2d_pkg::CORDIC_GAIN;
				y_q <= '0;
				i_q <= '0;
			end
			a2d_pkg::CR_FOLD2: begin
				if (r_q > a2d_pkg::ANG_HALF_PI) begin
					r_q <= r_q - a2d_pkg::ANG_PI;
					fneg_q <= 1'b1;
				end else if (r_q < -a2d_pkg::ANG_HALF_PI) begin
					r_q <= r_q + a2d_pkg::ANG_PI;
					fneg_q <= 1'b1;
				end
			end
			a2d_pkg::CR_ITER: begin
				if (r_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					r_q <= r_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					r_q <= r_q + at;
				end
				i_q <= i_q + 1'b1;
			end
			a2d_pkg::CR_FIN: begin
				sin_q <= 32'(ys >>> a2d_pkg::ANG_SHIFT);
				cos_q <= 32'(xs >>> a2d_pkg::ANG_SHIFT);
			end
			default: begin
			end
		endcase
	end
endmodule

// File: rtl/core/affine_2d_transform_unit.sv
// Top level of the 2D affine transform unit: matrix registers, micro-op
// sequencer and the shared multiplier, divider and CORDIC units.
// Depends on a2d_pkg, a2d_in_if, a2d_out_if, a2d_mul, a2d_div, a2d_cordic.

// One transaction is taken at a time; ready is high only while the sequencer
// is idle. Identity and the unused code go straight to the result. Translate,
// scale and apply run four products and determinant two, each in an issue
// and an accumulate state on the shared multiplier. Rotate first runs range
// reduction, folding and the 30 CORDIC iterations, then eight products;
// operands and matrix entries are signed Q16.16. Invert runs two products,
// four divisions on the shared divider, which yields one quotient bit per
// cycle over DIV_W bits, 50 at Q16.16, and four more products; it stops
// after the determinant when that is zero. A finished result sits in an
// output register while the next transaction is accepted.
module affine_2d_transform_unit (
	input logic clk,
	input logic arst_n,
	a2d_in_if.sink in_ch,
	a2d_out_if.source out_ch
);
	localparam int AW = a2d_pkg::ACC_W;
	localparam int DW = a2d_pkg::DIV_W;

	a2d_pkg::ctl_state_t state_q;
	a2d_pkg::ctl_state_t state_d;
	logic [2:0] func_q;
	logic signed [31:0] opa_q;
	logic signed [31:0] opb_q;
	logic signed [31:0] m_q [6];
	logic signed [31:0] n_q [6];
	logic [3:0] uidx_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] d_q;
	logic signed [31:0] rx_q;
	logic signed [31:0] ry_q;
	logic sing_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic out_s_q;
	logic out_valid_q;

	a2d_pkg::uop_t uop;
	logic accept;
	logic emit;
	logic cor_start;
	logic cor_done;
	logic div_start;
	logic div_done;
	logic signed [31:0] sin_v;
	logic signed [31:0] cos_v;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [a2d_pkg::PROD_W-1:0] prod;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] add_ext;
	logic signed [AW-1:0] acc_nx;
	logic signed [DW-1:0] dvd;
	logic signed [DW-1:0] quot;
	logic singular_hit;

	function automatic logic signed [31:0] pick(input a2d_pkg::src_t s,
			input logic signed [31:0] m0, input logic signed [31:0] m1,
			input logic signed [31:0] m2, input logic signed [31:0] m3,
			input logic signed [31:0] m4, input logic signed [31:0] m5,
			input logic signed [31:0] n0, input logic signed [31:0] n1,
			input logic signed [31:0] n3, input logic signed [31:0] n4,
			input logic signed [31:0] oa, input logic signed [31:0] ob,
			input logic signed [31:0] sn, input logic signed [31:0] cs);
		logic signed [31:0] v;
		case (s)
			a2d_pkg::SRC_M0: v = m0;
			a2d_pkg::SRC_M1: v = m1;
			a2d_pkg::SRC_M2: v = m2;
			a2d_pkg::SRC_M3: v = m3;
			a2d_pkg::SRC_M4: v = m4;
			a2d_pkg::SRC_M5: v = m5;
			a2d_pkg::SRC_N0: v = n0;
			a2d_pkg::SRC_N1: v = n1;
			a2d_pkg::SRC_N3: v = n3;
			a2d_pkg::SRC_N4: v = n4;
			a2d_pkg::SRC_A: v = oa;
			a2d_pkg::SRC_B: v = ob;
			a2d_pkg::SRC_SIN: v = sn;
			a2d_pkg::SRC_NSIN: v = -sn;
			a2d_pkg::SRC_COS: v = cs;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign uop = a2d_pkg::uop_lookup(func_q, uidx_q);
	assign mul_a = pick(uop.src_a, m_q[0], m_q[1], m_q[2], m_q[3], m_q[4], m_q[5],
		n_q[0], n_q[1], n_q[3], n_q[4], opa_q, opb_q, sin_v, cos_v);
	assign mul_b = pick(uop.src_b, m_q[0], m_q[1], m_q[2], m_q[3], m_q[4], m_q[5],
		n_q[0], n_q[1], n_q[3], n_q[4], opa_q, opb_q, sin_v, cos_v);

	assign prod_ext = AW'(prod);
	always_comb begin
		case (uop.addend)
			a2d_pkg::ADD_M2: add_ext = AW'(m_q[2]);
			a2d_pkg::ADD_M5: add_ext = AW'(m_q[5]);
			default: add_ext = '0;
		endcase
		case (uop.mode)
			a2d_pkg::MD_LOAD: acc_nx = prod_ext + add_ext;
			a2d_pkg::MD_ADD: acc_nx = acc_q + prod_ext;
			default: acc_nx = acc_q - prod_ext;
		endcase
	end

	assign dvd = (uop.mode == a2d_pkg::MD_SUB) ? (-DW'(mul_a)) <<< a2d_pkg::FRAC_BITS
		: DW'(mul_a) <<< a2d_pkg::FRAC_BITS;
	assign singular_hit = (uop.fin == a2d_pkg::FIN_DET) && (acc_nx == '0);

	a2d_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.prod_q(prod)
	);

	a2d_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dvd),
		.divisor(DW'(d_q)),
		.done(div_done),
		.quot(quot)
	);

	a2d_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(opa_q),
		.done(cor_done),
		.sin_q(sin_v),
		.cos_q(cos_v)
	);

	assign in_ch.ready = (state_q == a2d_pkg::CS_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.result_x = out_x_q;
	assign out_ch.result_y = out_y_q;
	assign out_ch.singular = out_s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= a2d_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept = 1'b0;
		emit = 1'b0;
		cor_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			a2d_pkg::CS_IDLE: begin
				if (in_ch.valid) begin
					accept = 1'b1;
					case (in_ch.func)
						a2d_pkg::FN_ROTATE: state_d = a2d_pkg::CS_CORDIC;
						a2d_pkg::FN_TRANSLATE, a2d_pkg::FN_SCALE, a2d_pkg::FN_APPLY,
						a2d_pkg::FN_INVERT, a2d_pkg::FN_DET: state_d = a2d_pkg::CS_ISSUE;
						default: state_d = a2d_pkg::CS_DONE;
					endcase
				end
			end
			a2d_pkg::CS_CORDIC: begin
				if (func_q == a2d_pkg::FN_ROTATE && !cor_done && uidx_q == 4'd15) begin
					cor_start = 1'b1;
				end
				if (cor_done) state_d = a2d_pkg::CS_ISSUE;
			end
			a2d_pkg::CS_ISSUE: begin
				if (uop.kind == a2d_pkg::UK_DIV) begin
					div_start = 1'b1;
					state_d = a2d_pkg::CS_DIV;
				end else begin
					state_d = a2d_pkg::CS_ACC;
				end
			end
			a2d_pkg::CS_ACC: begin
				if (uop.last || singular_hit) state_d = a2d_pkg::CS_DONE;
				else state_d = a2d_pkg::CS_ISSUE;
			end
			a2d_pkg::CS_DIV: begin
				if (div_done) state_d = uop.last ? a2d_pkg::CS_DONE : a2d_pkg::CS_ISSUE;
			end
			a2d_pkg::CS_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					emit = 1'b1;
					state_d = a2d_pkg::CS_IDLE;
				end
			end
			default: state_d = a2d_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			m_q[0] <= a2d_pkg::ONE_Q;
			m_q[1] <= '0;
			m_q[2] <= '0;
			m_q[3] <= '0;
			m_q[4] <= a2d_pkg::ONE_Q;
			m_q[5] <= '0;
			uidx_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				for (int k = 0; k < 6; k++) m_q[k] <= n_q[k];
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				// The rotation start is keyed off this marker value.
				uidx_q <= (in_ch.func == a2d_pkg::FN_ROTATE) ? 4'd15 : 4'd0;
			end else if (state_q == a2d_pkg::CS_CORDIC) begin
				uidx_q <= 4'd0;
			end else if ((state_q == a2d_pkg::CS_ACC && !uop.last)
					|| (state_q == a2d_pkg::CS_DIV && div_done && !uop.last)) begin
				uidx_q <= uidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_ch.func;
			opa_q <= in_ch.operand_a;
			opb_q <= in_ch.operand_b;
			rx_q <= '0;
			ry_q <= '0;
			sing_q <= 1'b0;
			if (in_ch.func == a2d_pkg::FN_IDENT) begin
				for (int k = 0; k < 6; k++) n_q[k] <= '0;
				n_q[0] <= a2d_pkg::ONE_Q;
				n_q[4] <= a2d_pkg::ONE_Q;
			end else begin
				for (int k = 0; k < 6; k++) n_q[k] <= m_q[k];
			end
		end
		if (state_q == a2d_pkg::CS_ACC) begin
			acc_q <= acc_nx;
			case (uop.fin)
				a2d_pkg::FIN_WR: n_q[uop.dst] <= a2d_pkg::sat_acc(acc_nx);
				a2d_pkg::FIN_WRNEG: n_q[uop.dst] <= a2d_pkg::sat_acc(-acc_nx);
				a2d_pkg::FIN_OUTX: rx_q <= a2d_pkg::sat_acc(acc_nx);
				a2d_pkg::FIN_OUTY: ry_q <= a2d_pkg::sat_acc(acc_nx);
				a2d_pkg::FIN_DET: begin
					d_q <= acc_nx;
					if (singular_hit) begin
						for (int k = 0; k < 6; k++) n_q[k] <= '0;
						sing_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == a2d_pkg::CS_DIV && div_done) begin
			n_q[uop.dst] <= a2d_pkg::sat_div(quot);
		end
		if (emit) begin
			out_x_q <= rx_q;
			out_y_q <= ry_q;
			out_s_q <= sing_q;
		end
	end
endmodule

// File: test/testbench.sv
// Self-checking testbench for the 2D affine transform unit.
// Depends on a2d_pkg, a2d_in_if, a2d_out_if and affine_2d_transform_unit.
// A predictor keeps its own matrix and checks every result transaction in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam longint LIMIT = 2000000;
	localparam longint Q_ONE = 64'sd1 <<< a2d_pkg::FRAC_BITS;
	localparam longint R_PI = 64'sd3373259426;
	localparam longint R_TWO_PI = 64'sd6746518852;
	localparam longint R_HALF_PI = 64'sd1686629713;
	localparam longint R_GAIN = 64'sd652032874;
	localparam longint ARCTAN [30] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic singular;
	} point_result_t;

	logic clk;
	logic arst_n;
	a2d_in_if in_ch ();
	a2d_out_if out_ch ();

	affine_2d_transform_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	longint matrix [6];
	point_result_t pending_results [$];
	int fail_count = 0;
	longint cycle_count = 0;
	int hold_off_cycles = 0;
	bit steady = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint fmul(input longint a, input longint b);
		return (a * b) >>> a2d_pkg::FRAC_BITS;
	endfunction

	function automatic void sine_cosine(input longint ang, output longint s, output longint c);
		longint r, x, y, dx, dy;
		bit flip;
		r = (ang * (64'sd1 <<< (30 - a2d_pkg::FRAC_BITS))) % R_TWO_PI;
		flip = 0;
		x = R_GAIN;
		y = 0;
		if (r > R_PI) begin
			r -= R_TWO_PI;
		end else if (r < -R_PI) begin
			r += R_TWO_PI;
		end
		if (r > R_HALF_PI) begin
			r -= R_PI;
			flip = 1;
		end else if (r < -R_HALF_PI) begin
			r += R_PI;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx;
				y += dy;
				r -= ARCTAN[i];
			end else begin
				x += dx;
				y -= dy;
				r += ARCTAN[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y >>> (30 - a2d_pkg::FRAC_BITS);
		c = x >>> (30 - a2d_pkg::FRAC_BITS);
	endfunction

	function automatic void load_identity();
		foreach (matrix[i]) matrix[i] = 0;
		matrix[0] = Q_ONE;
		matrix[4] = Q_ONE;
	endfunction

	function automatic point_result_t transform_step(input logic [2:0] fn,
			input logic signed [31:0] opa, input logic signed [31:0] opb);
		point_result_t res;
		longint a, b, s, c, e00, e10, d;
		longint n [6];
		a = opa;
		b = opb;
		res = '{x: 0, y: 0, singular: 0};
		case (fn)
			a2d_pkg::FN_IDENT: begin
				load_identity();
			end
			a2d_pkg::FN_TRANSLATE: begin
				matrix[2] = sat32(fmul(matrix[0], a) + fmul(matrix[1], b) + matrix[2]);
				matrix[5] = sat32(fmul(matrix[3], a) + fmul(matrix[4], b) + matrix[5]);
			end
			a2d_pkg::FN_SCALE: begin
				matrix[0] = sat32(fmul(matrix[0], a));
				matrix[3] = sat32(fmul(matrix[3], a));
				matrix[1] = sat32(fmul(matrix[1], b));
				matrix[4] = sat32(fmul(matrix[4], b));
			end
			a2d_pkg::FN_ROTATE: begin
				sine_cosine(a, s, c);
				e00 = matrix[0];
				e10 = matrix[3];
				matrix[0] = sat32(fmul(e00, c) + fmul(matrix[1], s));
				matrix[1] = sat32(fmul(e00, -s) + fmul(matrix[1], c));
				matrix[3] = sat32(fmul(e10, c) + fmul(matrix[4], s));
				matrix[4] = sat32(fmul(e10, -s) + fmul(matrix[4], c));
			end
			a2d_pkg::FN_APPLY: begin
				res.x = 32'(sat32(fmul(matrix[0], a) + fmul(matrix[1], b) + matrix[2]));
				res.y = 32'(sat32(fmul(matrix[3], a) + fmul(matrix[4], b) + matrix[5]));
			end
			a2d_pkg::FN_INVERT: begin
				d = fmul(matrix[0], matrix[4]) - fmul(matrix[1], matrix[3]);
				if (d == 0) begin
					foreach (matrix[i]) matrix[i] = 0;
					res.singular = 1;
				end else begin
					n[0] = sat32((matrix[4] * Q_ONE) / d);
					n[1] = sat32((-matrix[1] * Q_ONE) / d);
					n[3] = sat32((-matrix[3] * Q_ONE) / d);
					n[4] = sat32((matrix[0] * Q_ONE) / d);
					n[2] = sat32(-(fmul(n[0], matrix[2]) + fmul(n[1], matrix[5])));
					n[5] = sat32(-(fmul(n[3], matrix[2]) + fmul(n[4], matrix[5])));
					foreach (matrix[i]) matrix[i] = n[i];
				end
			end
			a2d_pkg::FN_DET: begin
				res.x = 32'(sat32(fmul(matrix[0], matrix[4]) - fmul(matrix[1], matrix[3])));
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 40);
	endfunction

	task automatic send_op(input logic [2:0] fn, input logic signed [31:0] opa,
			input logic signed [31:0] opb);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.operand_a <= opa;
		in_ch.operand_b <= opb;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			if (taken) begin
				pending_results.push_back(transform_step(fn, opa, opb));
			end
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else if (steady) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) < 75);
		end
	end

	always @(negedge clk) begin
		point_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.result_x !== exp_r.x) begin
					$error("result_x expected %0d actual %0d", exp_r.x, out_ch.result_x);
					fail_count++;
				end
				if (out_ch.result_y !== exp_r.y) begin
					$error("result_y expected %0d actual %0d", exp_r.y, out_ch.result_y);
					fail_count++;
				end
				if (out_ch.singular !== exp_r.singular) begin
					$error("singular expected %0b actual %0b", exp_r.singular,
						out_ch.singular);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] small_q(input int lo, input int hi);
		return 32'(int'($urandom_range(0, hi - lo)) + lo);
	endfunction

	task automatic test_extremes();
		logic signed [31:0] vals [6];
		vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sd1, -32'sd1, 32'sh00010000};
		send_op(a2d_pkg::FN_APPLY, vals[0], vals[1]);
		send_op(a2d_pkg::FN_DET, 0, 0);
		send_op(a2d_pkg::FN_SCALE, vals[0], vals[1]);
		send_op(a2d_pkg::FN_APPLY, vals[0], vals[0]);
		send_op(a2d_pkg::FN_TRANSLATE, vals[1], vals[1]);
		send_op(a2d_pkg::FN_APPLY, vals[4], vals[3]);
		send_op(a2d_pkg::FN_DET, 0, 0);
		send_op(a2d_pkg::FN_INVERT, 0, 0);
		send_op(a2d_pkg::FN_IDENT, vals[0], vals[1]);
		send_op(FN_UNUSED, vals[0], vals[1]);
		send_op(a2d_pkg::FN_APPLY, vals[5], vals[4]);
	endtask

	task automatic test_rotate();
		logic signed [31:0] angles [8];
		angles = '{32'sd102944, -32'sd102944, 32'sd205887, -32'sd205887, 32'sd51472,
			32'sh7FFFFFFF, 32'sh80000000, 32'sd411775};
		foreach (angles[i]) begin
			send_op(a2d_pkg::FN_ROTATE, angles[i], 0);
			send_op(a2d_pkg::FN_APPLY, 32'sh00010000, 32'sh00020000);
		end
		send_op(a2d_pkg::FN_IDENT, 0, 0);
	endtask

	task automatic test_invert();
		send_op(a2d_pkg::FN_SCALE, 32'sh00020000, 32'sh00008000);
		send_op(a2d_pkg::FN_TRANSLATE, 32'sh00030000, -32'sh00050000);
		send_op(a2d_pkg::FN_INVERT, 0, 0);
		send_op(a2d_pkg::FN_APPLY, 32'sh00010000, 32'sh00010000);
		send_op(a2d_pkg::FN_SCALE, 0, 32'sh00010000);
		send_op(a2d_pkg::FN_INVERT, 0, 0);
		send_op(a2d_pkg::FN_DET, 0, 0);
		send_op(a2d_pkg::FN_IDENT, 0, 0);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_off_cycles = 600;
		for (int i = 0; i < 6; i++) begin
			send_op(logic'(i[0]) ? a2d_pkg::FN_APPLY : a2d_pkg::FN_TRANSLATE,
				small_q(-300000, 300000), small_q(-300000, 300000));
		end
		wait_drained();
	endtask

	task automatic random_op();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			send_op(3'($urandom_range(0, 7)), $urandom, $urandom);
		end else if (kind < 25) begin
			send_op(a2d_pkg::FN_TRANSLATE, small_q(-65536000, 65536000),
				small_q(-65536000, 65536000));
		end else if (kind < 40) begin
			send_op(a2d_pkg::FN_SCALE, small_q(-262144, 262144), small_q(-262144, 262144));
		end else if (kind < 55) begin
			send_op(a2d_pkg::FN_ROTATE, ($urandom_range(0, 3) == 0) ? 32'($urandom) :
				small_q(-823550, 823550), $urandom);
		end else if (kind < 82) begin
			send_op(a2d_pkg::FN_APPLY, small_q(-6553600, 6553600),
				small_q(-6553600, 6553600));
		end else if (kind < 92) begin
			send_op(a2d_pkg::FN_DET, $urandom, $urandom);
		end else begin
			send_op(a2d_pkg::FN_INVERT, $urandom, $urandom);
		end
	endtask

	task automatic test_random(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			send_op(a2d_pkg::FN_IDENT, $urandom, $urandom);
			sent++;
			steady = ($urandom_range(0, 9) == 0);
			for (int j = $urandom_range(3, 14); j > 0; j--) begin
				random_op();
				sent++;
			end
			steady = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = a2d_pkg::FN_IDENT;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		out_ch.ready = 1'b0;
		load_identity();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_rotate();
		test_invert();
		test_backpressure();
		test_random(670);
		wait_drained();
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// File: affine_2d_transform_unit.f
rtl/core/a2d_pkg.sv
rtl/core/a2d_in_if.sv
rtl/core/a2d_out_if.sv
rtl/core/a2d_mul.sv
rtl/core/a2d_div.sv
rtl/core/a2d_cordic.sv
rtl/core/affine_2d_transform_unit.sv
test/testbench.sv
